/* rtl/tfc_pkg.sv */
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, codes and helpers of the TDC fine phase calibrator.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int DIV_STAGES = 34;

  localparam logic OP_HIT   = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] METH_NONE = 2'd0;
  localparam logic [1:0] METH_EDGE = 2'd1;
  localparam logic [1:0] METH_FIT  = 2'd2;

  localparam logic [15:0] RTC_RESET = 16'd32768;
  // -9999.0 in Q16.16
  localparam logic signed [31:0] PHASE_MARK = 32'shD8F1_0000;

  localparam int ENTRY_W = 98;

  typedef struct packed {
    logic        op;
    logic        in_range;
    logic [9:0]  chan;
    logic [31:0] roll;
    logic [15:0] coarse;
    logic [7:0]  fine;
    logic [1:0]  method;
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
  } item_t;

  typedef struct packed {
    logic        cal;
    logic        inv;
    logic        eq;
    logic        fit;
    logic        neg;
    logic [31:0] fit_phase;
    logic [31:0] p2;
    logic [48:0] base;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/tfc_if.sv */
// ----------------------------------------------------------------------------
// tfc interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface tfc_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [9:0]         channel;
  logic [31:0]        rollover;
  logic [15:0]        coarse;
  logic [7:0]         fine;
  logic [1:0]         method;
  logic signed [31:0] param_first;
  logic signed [31:0] param_second;
  logic signed [31:0] param_third;
  modport source (output valid, opcode, channel, rollover, coarse, fine, method,
                  param_first, param_second, param_third, input ready);
  modport sink (input valid, opcode, channel, rollover, coarse, fine, method,
                param_first, param_second, param_third, output ready);
endinterface

interface tfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] phase;
  logic signed [63:0] hit_time;
  logic               calibrated;
  logic               inverted_edges;
  modport source (output valid, phase, hit_time, calibrated, inverted_edges,
                  input ready);
  modport sink (input valid, phase, hit_time, calibrated, inverted_edges,
                output ready);
endinterface

interface tfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/tfc_ram.sv */
// ----------------------------------------------------------------------------
// tfc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tfc_front.sv */
// ----------------------------------------------------------------------------
// tfc_front
// Accepts items, checks the channel range and queues them for the back end.
// ----------------------------------------------------------------------------
module tfc_front #(
  parameter int CHANNELS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  tfc_in_if.sink         in_ch,
  input  logic           blocked,
  output tfc_pkg::item_t head,
  output logic           avail,
  input  logic           pop
);

  localparam int PW = $clog2(tfc_pkg::FIFO_DEPTH);

  tfc_pkg::item_t mem [tfc_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           push;
  tfc_pkg::item_t item;

  assign in_ch.ready = (count != (PW+1)'(tfc_pkg::FIFO_DEPTH)) && !blocked;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    item.op       = in_ch.opcode;
    item.in_range = {22'd0, in_ch.channel} < 32'(CHANNELS);
    item.chan     = in_ch.channel;
    item.roll     = in_ch.rollover;
    item.coarse   = in_ch.coarse;
    item.fine     = in_ch.fine;
    item.method   = in_ch.method;
    item.p0       = in_ch.param_first;
    item.p1       = in_ch.param_second;
    item.p2       = in_ch.param_third;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head  = mem[rd_ptr];
  assign avail = count != '0;

endmodule

/* rtl/tfc_div.sv */
// ----------------------------------------------------------------------------
// tfc_div
// Pipelined restoring divider, one quotient bit per stage, magnitude
// clamped at 2^33, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module tfc_div #(
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [47:0]   in_n,
  input  logic [31:0]   in_d,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [33:0]   out_q,
  output logic [SW-1:0] out_side
);

  localparam int ST = tfc_pkg::DIV_STAGES;

  logic          vld  [ST];
  logic [47:0]   rem  [ST];
  logic [31:0]   dv   [ST];
  logic          sat  [ST];
  logic [33:0]   quo  [ST];
  logic [SW-1:0] side [ST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // first stage decides whether the quotient reaches 2^33
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= in_n;
      dv[0]   <= in_d;
      sat[0]  <= {17'd0, in_n} >= {in_d, 33'd0};
      quo[0]  <= ({17'd0, in_n} >= {in_d, 33'd0}) ? {1'b1, 33'd0} : 34'd0;
      side[0] <= in_side;
    end
  end

  for (genvar k = 1; k < ST; k++) begin : g_stage
    localparam int BIT = ST - 1 - k;
    logic [64:0] shd;
    logic        take;
    assign shd  = {33'd0, dv[k-1]} << BIT;
    assign take = !sat[k-1] && ({17'd0, rem[k-1]} >= shd);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? rem[k-1] - shd[47:0] : rem[k-1];
        dv[k]   <= dv[k-1];
        sat[k]  <= sat[k-1];
        quo[k]  <= take ? (quo[k-1] | (34'd1 << BIT)) : quo[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[ST-1];
  assign out_q     = quo[ST-1];
  assign out_side  = side[ST-1];

endmodule

/* rtl/tfc_back.sv */
// ----------------------------------------------------------------------------
// tfc_back
// Calibration table, table clear after reset, phase and hit time pipeline.
// ----------------------------------------------------------------------------
module tfc_back #(
  parameter int CHANNELS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  tfc_pkg::item_t head,
  input  logic           avail,
  output logic           pop,
  output logic           clearing,
  input  logic [15:0]    rtc,
  tfc_out_if.source      out_ch
);

  localparam int AW = $clog2(CHANNELS);
  localparam int SW = $bits(tfc_pkg::side_t);

  logic                 adv;
  logic [AW-1:0]        clr_addr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [tfc_pkg::ENTRY_W-1:0] wdata;
  logic [tfc_pkg::ENTRY_W-1:0] rdata;
  logic [47:0]          roll_prod;

  assign adv = !out_ch.valid || out_ch.ready;
  assign pop = avail && adv && !clearing;

  // table clear after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(CHANNELS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign we    = clearing || (pop && head.op == tfc_pkg::OP_WRITE && head.in_range);
  assign waddr = clearing ? clr_addr : AW'(head.chan);
  assign wdata = clearing ? '0 : {head.method, head.p0, head.p1, head.p2};

  tfc_ram #(.WIDTH(tfc_pkg::ENTRY_W), .DEPTH(CHANNELS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (AW'(head.chan)),
    .rdata (rdata)
  );

  // lookup stage
  logic        s1_valid;
  logic        s1_in_range;
  logic [7:0]  s1_fine;
  logic [48:0] s1_base;

  assign roll_prod = {16'd0, head.roll} * {32'd0, rtc};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop && head.op == tfc_pkg::OP_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_in_range <= head.in_range;
      s1_fine     <= head.fine;
      s1_base     <= {1'b0, roll_prod} + {33'd0, head.coarse};
    end
  end

  logic [1:0]         m;
  logic signed [31:0] p0;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [33:0] f34;
  logic signed [33:0] p0e;
  logic signed [33:0] p1e;
  logic signed [33:0] n;
  logic signed [33:0] d;
  logic [33:0]        nmag;
  logic [33:0]        dmag;
  logic signed [40:0] fit_prod;
  logic signed [41:0] fit_diff;
  tfc_pkg::side_t     side_in;

  always_comb begin
    m        = s1_in_range ? rdata[97:96] : tfc_pkg::METH_NONE;
    p0       = rdata[95:64];
    p1       = rdata[63:32];
    p2       = rdata[31:0];
    f34      = $signed({10'd0, s1_fine, 16'd0});
    p0e      = 34'(p0);
    p1e      = 34'(p1);
    n        = f34 - p0e;
    d        = p1e - p0e;
    nmag     = n[33] ? -n : n;
    dmag     = d[33] ? -d : d;
    fit_prod = $signed({1'b0, s1_fine}) * p0;
    fit_diff = fit_prod - p1;

    side_in.cal       = (m == tfc_pkg::METH_EDGE) || (m == tfc_pkg::METH_FIT);
    side_in.fit       = m == tfc_pkg::METH_FIT;
    side_in.eq        = p0 == p1;
    side_in.inv       = (m == tfc_pkg::METH_EDGE) && (p1e < f34) && (p0e > f34);
    side_in.neg       = n[33] ^ d[33];
    side_in.fit_phase = tfc_pkg::sat32(64'(fit_diff));
    side_in.p2        = p2;
    side_in.base      = s1_base;
  end

  logic           dv_valid;
  logic [33:0]    dv_q;
  logic [SW-1:0]  dv_side_bits;
  tfc_pkg::side_t dv_side;

  tfc_div #(.SW(SW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .in_n      ({nmag[31:0], 16'd0}),
    .in_d      (dmag[31:0]),
    .in_side   (side_in),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side_bits)
  );

  assign dv_side = dv_side_bits;

  // final phase selection and hit time
  logic signed [34:0] qs;
  logic signed [35:0] de;
  logic signed [31:0] phase_sel;
  logic signed [32:0] neg_phase;
  logic signed [32:0] adj;
  logic [63:0]        time_sel;

  always_comb begin
    qs = dv_side.neg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
    de = qs - $signed(dv_side.p2);
    if (!dv_side.cal) begin
      phase_sel = '0;
    end else if (dv_side.fit) begin
      phase_sel = dv_side.fit_phase;
    end else if (dv_side.eq) begin
      phase_sel = '0;
    end else if (dv_side.inv) begin
      phase_sel = tfc_pkg::PHASE_MARK;
    end else begin
      phase_sel = tfc_pkg::sat32(64'(de));
    end
    neg_phase = -(33'(phase_sel));
    adj       = neg_phase >>> 2;
    time_sel  = {1'b0, dv_side.base, 14'd0} + 64'(adj);
  end

  logic               out_valid;
  logic signed [31:0] out_phase;
  logic [63:0]        out_time;
  logic               out_cal;
  logic               out_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_phase <= phase_sel;
      out_time  <= time_sel;
      out_cal   <= dv_side.cal;
      out_inv   <= dv_side.cal && !dv_side.fit && !dv_side.eq && dv_side.inv;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.phase          = out_phase;
  assign out_ch.hit_time       = out_time;
  assign out_ch.calibrated     = out_cal;
  assign out_ch.inverted_edges = out_inv;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    pop |-> !clearing) else $error("item taken during table clear");

  a_inv_needs_cal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_inv |-> out_cal && out_phase == tfc_pkg::PHASE_MARK)
    else $error("inverted edge flag without edge calibration");

  a_uncal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_cal |-> out_phase == '0 && !out_inv)
    else $error("uncalibrated hit with nonzero phase");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_time))
    else $error("result changed while stalled");

endmodule

/* rtl/tdc_fine_phase_calibrator_unit.sv */
// ----------------------------------------------------------------------------
// tdc_fine_phase_calibrator_unit
// Per-channel fine phase calibration and hit time formation for TDC hits.
// ----------------------------------------------------------------------------
// in_ch carries hits (opcode 0) and calibration table writes (opcode 1);
// a transaction happens when valid and ready are both high. Each hit gives
// one transaction on out_ch with the fine phase (Q16.16), the hit time
// (Q49.14) and the calibration flags; table writes give none.
// cfg writes the coarse cycles per rollover count; it is always ready and
// takes effect at once.
// Throughput is one item per cycle while out_ch is ready and no table
// sweep runs. With out_ch ready, the result transaction follows the input
// transaction through the input queue, the table read, a 34-stage divider
// pipeline for the edge interpolation, and the output register.
// After reset the method table is swept to zero, one entry per cycle;
// in_ch.ready stays low during the sweep.
// When out_ch stalls the whole back pipeline holds; the input queue keeps
// taking items until it fills, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module tdc_fine_phase_calibrator_unit #(
  parameter int CHANNELS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  tfc_in_if.sink     in_ch,
  tfc_out_if.source  out_ch,
  tfc_cfg_if.sink    cfg
);

  logic [15:0]    rtc;
  tfc_pkg::item_t head;
  logic           avail;
  logic           pop;
  logic           clearing;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rtc <= tfc_pkg::RTC_RESET;
    end else if (cfg.valid && cfg.ready) begin
      rtc <= cfg.data;
    end
  end

  tfc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .blocked (clearing),
    .head    (head),
    .avail   (avail),
    .pop     (pop)
  );

  tfc_back #(.CHANNELS(CHANNELS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .avail    (avail),
    .pop      (pop),
    .clearing (clearing),
    .rtc      (rtc),
    .out_ch   (out_ch)
  );

endmodule
